// ===== rtl/lfb_pkg.sv =====
// ---------------------------------------------------------------------------
// lfb_pkg
// Shared types, register and operation codes, and the exp2 factor table for
// the Lafortune BRDF evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package lfb_pkg;

  localparam int MAX_LOBES_DEFAULT = 4;
  localparam int LOBE_REGS         = 4;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int MUL_W             = 34;
  localparam int ONE_Q14           = 16384;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOBE_COUNT    = 3'd0,
    REG_LOBE_0        = 3'd1,
    REG_LOBE_1        = 3'd2,
    REG_LOBE_2        = 3'd3,
    REG_LOBE_3        = 3'd4,
    REG_DIFFUSE_SCALE = 3'd5,
    REG_LOBE_SCALE    = 3'd6,
    REG_FALLOFF_SCALE = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_FULL       = 2'd0,
    OP_NO_DIFFUSE = 2'd1,
    OP_TABLE      = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M_LX, ST_M_LZ, ST_M_NL, ST_DOT, ST_CLAMP,
    ST_LOBE_X, ST_LOBE_Y, ST_LOBE_Z, ST_LOBE_V, ST_PW_START,
    ST_LOG_SQ, ST_LOG_NORM, ST_LOG_MAG, ST_LOG_EXP,
    ST_EXP_MUL, ST_EXP_UPD, ST_EXP_FIN, ST_FIN,
    ST_BR_F, ST_BR_G, ST_BR_G2, ST_BR_H, ST_BR_HI, ST_BR_LO, ST_BR_D, ST_BR_SUM,
    ST_OUT
  } state_t;

  typedef logic [16:0][30:0] exp_tab_t;

  // floor square root, one result bit per pass
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factors 2^-(2^-j) in Q1.30, each the square root of the one before
  function automatic exp_tab_t build_exp_fac();
    exp_tab_t t;
    logic [63:0] x;
    x = 64'd1 << 29;
    t[0] = x[30:0];
    for (int j = 1; j <= 16; j++) begin
      x = isqrt64(x << 30);
      t[j] = x[30:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_FAC = build_exp_fac();

endpackage

`default_nettype wire

// ===== rtl/lafortune_brdf_evaluator_core.sv =====
// ---------------------------------------------------------------------------
// lafortune_brdf_evaluator_core
// Multi-lobe Lafortune BRDF evaluator in fixed point, built around one shared
// signed multiplier driven by a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: an operation code,
//   light and view directions in Q1.14, and two dot products for table
//   entries. Output channel (out_valid/out_ready) returns brdf_value (Q16.16,
//   saturated) and lobe_byte. Configuration channel (cfg_valid/cfg_ready) is
//   always ready; write it only while the block is idle.
//   One request is in flight at a time; in_ready is high only when idle.
//   The 16-step log2 squaring loop and the 16-step exp2 product loop of each
//   lobe's power term share the single multiplier. A lobe with zero exponent
//   or a clamped lobe value of 0 or 1 skips both loops; an exponent whose
//   integer part is above forty skips the exp2 loop and gives zero.
//   Operation 3 returns zeros in the cycle after accept.
//   Reset restores the register defaults (one lobe, unit scales, no falloff)
//   and empties the block. A stalled receiver holds the result in the output
//   registers; no new request is taken until it is delivered.
// ---------------------------------------------------------------------------
`default_nettype none

module lafortune_brdf_evaluator_core
  import lfb_pkg::*;
#(
  parameter int MAX_LOBES = MAX_LOBES_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [CFG_DATA_W-1:0]        cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   operation,
  input  wire  signed [15:0]           light_x,
  input  wire  signed [15:0]           light_y,
  input  wire  signed [15:0]           light_z,
  input  wire  signed [15:0]           view_x,
  input  wire  signed [15:0]           view_y,
  input  wire  signed [15:0]           view_z,
  input  wire  signed [15:0]           lateral_dot,
  input  wire  signed [15:0]           normal_dot,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [31:0]           brdf_value,
  output logic [7:0]                   lobe_byte
);

  // lobes that can actually be configured and summed
  localparam int LOBE_N = (MAX_LOBES < LOBE_REGS) ? MAX_LOBES : LOBE_REGS;
  localparam int CNT_W  = $clog2(LOBE_N + 1);
  localparam int IDX_W  = (LOBE_N > 1) ? $clog2(LOBE_N) : 1;
  localparam int SUM_W  = 15 + CNT_W;

  // configuration registers
  logic [2:0]          lobe_count;
  logic [63:0]         lobe [LOBE_N];
  logic signed [31:0]  diffuse_scale;
  logic signed [31:0]  lobe_scale;
  logic signed [31:0]  falloff_scale;

  // sequencer
  state_t state, state_next;

  // latched request
  logic [1:0]          op;
  logic signed [15:0]  lx, ly, lz, vx, vy, vz;

  // datapath registers
  logic signed [2*MUL_W-1:0] prod;
  logic signed [63:0]        acc;
  logic signed [18:0]        lat;
  logic signed [16:0]        nrm;
  logic signed [15:0]        latc;
  logic [14:0]               nrmc, a_reg;
  logic [CNT_W-1:0]          cnt, idx;
  logic [SUM_W-1:0]          sum;
  logic [14:0]               sumc;
  logic [14:0]               x;
  logic [3:0]                p_reg;
  logic [31:0]               m;
  logic [15:0]               f;
  logic [5:0]                kreg;
  logic [15:0]               g;
  logic [30:0]               r;
  logic [4:0]                step;
  logic signed [33:0]        f16;
  logic signed [49:0]        g16;

  // combinational helpers
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [63:0]        prod64;
  logic [14:0]               nl;
  logic signed [15:0]        nv;
  logic signed [16:0]        nl_m1;
  logic [63:0]               lobe_cur;
  logic signed [15:0]        cx, cy, cz;
  logic [15:0]               n_exp;
  logic [CNT_W-1:0]          cnt_c;
  logic signed [15:0]        latc_c;
  logic [14:0]               nrmc_c, a_c;
  logic [15:0]               abs_sum;
  logic signed [63:0]        v_sum;
  logic signed [63:0]        v_c;
  logic [14:0]               x_c;
  logic [3:0]                p_c;
  logic [19:0]               mag_c;
  logic [63:0]               e_c;
  logic [31:0]               t_c;
  logic [63:0]               round_c;
  logic                      pw_done;
  logic [14:0]               pw_val;
  logic [14:0]               sumc_c;
  logic [23:0]               byte_c;
  logic signed [63:0]        total_c, rs_c;
  logic signed [31:0]        sat_c;

  assign cfg_ready = 1'b1;
  assign prod64    = prod[63:0];

  always_comb begin
    nl = (ly < 16'sd0) ? 15'd0 : ((ly > 16'sd16384) ? 15'd16384 : ly[14:0]);
    nv = vy[15] ? 16'sd0 : vy;
    nl_m1 = $signed({2'b00, nl}) - 17'sd16384;
    lobe_cur = lobe[idx[IDX_W-1:0]];
    cx = $signed(lobe_cur[15:0]);
    cy = $signed(lobe_cur[31:16]);
    cz = $signed(lobe_cur[47:32]);
    n_exp = lobe_cur[63:48];
    cnt_c = ({1'b0, lobe_count} > 4'(LOBE_N)) ? CNT_W'(LOBE_N) : CNT_W'(lobe_count);
    // clamp the dot products into the lobe unit's range
    latc_c = (lat < -19'sd16384) ? -16'sd16384 :
             ((lat > 19'sd16384) ? 16'sd16384 : lat[15:0]);
    nrmc_c = (nrm < 17'sd0) ? 15'd0 : ((nrm > 17'sd16384) ? 15'd16384 : nrm[14:0]);
    abs_sum = (latc_c[15] ? 16'(-latc_c) : 16'(latc_c)) + {1'b0, nrmc_c};
    a_c = (abs_sum > 16'd16384) ? 15'd16384 : abs_sum[14:0];
    // lobe value, rounded half up and clamped to [0,1]
    v_sum = acc + prod64 + 64'sd2048;
    v_c = v_sum >>> 12;
    x_c = (v_c < 64'sd0) ? 15'd0 : ((v_c > 64'sd16384) ? 15'd16384 : v_c[14:0]);
    p_c = 4'd0;
    for (int i = 0; i < 14; i++) begin
      if (x[i]) begin
        p_c = 4'(i);
      end
    end
    mag_c = {4'd14 - p_reg, 16'h0000} - {4'h0, f};
    e_c = 64'(prod64 + 64'sd128) >> 8;
    t_c = prod[61:30];
    round_c = (64'(r) + (64'd1 << (6'd15 + kreg))) >> (6'd16 + kreg);
    sumc_c = (sum > SUM_W'(ONE_Q14)) ? 15'd16384 : sum[14:0];
    byte_c = ((24'(sumc) << 8) - 24'(sumc) + 24'd8192) >> 14;
    total_c = acc + ((op == OP_FULL) ? prod64 : 64'sd0);
    rs_c = (total_c + 64'sd8192) >>> 14;
    sat_c = (rs_c > 64'sd2147483647) ? 32'sh7fffffff :
            ((rs_c < -64'sd2147483648) ? 32'sh80000000 : rs_c[31:0]);
  end

  // sequencer: next state, multiplier operands and lobe completion
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    pw_done    = 1'b0;
    pw_val     = 15'd0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (operation == OP_NONE) begin
            state_next = ST_OUT;
          end else if (operation == OP_TABLE) begin
            state_next = ST_CLAMP;
          end else begin
            state_next = ST_M_LX;
          end
        end
      end
      ST_M_LX: begin
        mul_a = MUL_W'(lx);
        mul_b = MUL_W'(vx);
        state_next = ST_M_LZ;
      end
      ST_M_LZ: begin
        mul_a = MUL_W'(lz);
        mul_b = MUL_W'(vz);
        state_next = ST_M_NL;
      end
      ST_M_NL: begin
        mul_a = $signed(MUL_W'(nl));
        mul_b = MUL_W'(nv);
        state_next = ST_DOT;
      end
      ST_DOT:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = (cnt_c == '0) ? ST_FIN : ST_LOBE_X;
      ST_LOBE_X: begin
        mul_a = MUL_W'(cx);
        mul_b = MUL_W'(latc);
        state_next = ST_LOBE_Y;
      end
      ST_LOBE_Y: begin
        mul_a = MUL_W'(cy);
        mul_b = $signed(MUL_W'(15'd16384 - a_reg));
        state_next = ST_LOBE_Z;
      end
      ST_LOBE_Z: begin
        mul_a = MUL_W'(cz);
        mul_b = $signed(MUL_W'(nrmc));
        state_next = ST_LOBE_V;
      end
      ST_LOBE_V: state_next = ST_PW_START;
      ST_PW_START: begin
        // zero exponent, zero base and unit base need no log/exp pass
        if (n_exp == 16'd0 || x == 15'd16384) begin
          pw_done = 1'b1;
          pw_val  = 15'd16384;
        end else if (x == 15'd0) begin
          pw_done = 1'b1;
        end else begin
          state_next = ST_LOG_SQ;
        end
      end
      ST_LOG_SQ: begin
        mul_a = $signed(MUL_W'(m));
        mul_b = $signed(MUL_W'(m));
        state_next = ST_LOG_NORM;
      end
      ST_LOG_NORM: state_next = (step == 5'd15) ? ST_LOG_MAG : ST_LOG_SQ;
      ST_LOG_MAG: begin
        mul_a = $signed(MUL_W'(mag_c));
        mul_b = $signed(MUL_W'(n_exp));
        state_next = ST_LOG_EXP;
      end
      ST_LOG_EXP: begin
        // integer part beyond forty underflows to zero
        if (e_c[28:16] > 13'd40) begin
          pw_done = 1'b1;
        end else begin
          state_next = ST_EXP_MUL;
        end
      end
      ST_EXP_MUL: begin
        mul_a = $signed(MUL_W'(r));
        mul_b = $signed(MUL_W'(EXP_FAC[step]));
        state_next = ST_EXP_UPD;
      end
      ST_EXP_UPD: state_next = (step == 5'd16) ? ST_EXP_FIN : ST_EXP_MUL;
      ST_EXP_FIN: begin
        pw_done = 1'b1;
        pw_val  = round_c[14:0];
      end
      ST_FIN: state_next = (op == OP_TABLE) ? ST_OUT : ST_BR_F;
      ST_BR_F: begin
        mul_a = MUL_W'(falloff_scale);
        mul_b = MUL_W'(nl_m1);
        state_next = ST_BR_G;
      end
      ST_BR_G: state_next = ST_BR_G2;
      ST_BR_G2: begin
        mul_a = f16;
        mul_b = MUL_W'(lobe_scale);
        state_next = ST_BR_H;
      end
      ST_BR_H: state_next = ST_BR_HI;
      ST_BR_HI: begin
        mul_a = MUL_W'(g16 >>> 17);
        mul_b = $signed(MUL_W'(sumc));
        state_next = ST_BR_LO;
      end
      ST_BR_LO: begin
        mul_a = $signed(MUL_W'(g16[16:0]));
        mul_b = $signed(MUL_W'(sumc));
        state_next = ST_BR_D;
      end
      ST_BR_D: begin
        mul_a = $signed(MUL_W'(nl));
        mul_b = MUL_W'(diffuse_scale);
        state_next = ST_BR_SUM;
      end
      ST_BR_SUM: state_next = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (pw_done) begin
      state_next = (idx == cnt - CNT_W'(1)) ? ST_FIN : ST_LOBE_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      lobe_count    <= 3'd1;
      diffuse_scale <= 32'sd65536;
      lobe_scale    <= 32'sd65536;
      falloff_scale <= 32'sd0;
      for (int i = 0; i < LOBE_N; i++) begin
        lobe[i] <= 64'd0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < LOBE_N; i++) begin
        if (cfg_index == CFG_INDEX_W'(REG_LOBE_0) + CFG_INDEX_W'(i)) begin
          lobe[i] <= cfg_data;
        end
      end
      unique case (cfg_index)
        REG_LOBE_COUNT:    lobe_count    <= cfg_data[2:0];
        REG_DIFFUSE_SCALE: diffuse_scale <= $signed(cfg_data[31:0]);
        REG_LOBE_SCALE:    lobe_scale    <= $signed(cfg_data[31:0]);
        REG_FALLOFF_SCALE: falloff_scale <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op         <= operation;
          lx         <= light_x;
          ly         <= light_y;
          lz         <= light_z;
          vx         <= view_x;
          vy         <= view_y;
          vz         <= view_z;
          lat        <= 19'(lateral_dot);
          nrm        <= 17'(normal_dot);
          brdf_value <= 32'sd0;
          lobe_byte  <= 8'd0;
        end
      end
      ST_M_LZ: acc <= prod64;
      ST_M_NL: acc <= acc + prod64;
      ST_DOT: begin
        lat <= 19'((acc + 64'sd8192) >>> 14);
        nrm <= 17'((prod64 + 64'sd8192) >>> 14);
      end
      ST_CLAMP: begin
        latc  <= latc_c;
        nrmc  <= nrmc_c;
        a_reg <= a_c;
        cnt   <= cnt_c;
        idx   <= '0;
        sum   <= '0;
      end
      ST_LOBE_Y: acc <= prod64;
      ST_LOBE_Z: acc <= acc + prod64;
      ST_LOBE_V: x <= x_c;
      ST_PW_START: begin
        p_reg <= p_c;
        m     <= 32'(x) << (5'd30 - 5'(p_c));
        f     <= 16'd0;
        step  <= 5'd0;
      end
      ST_LOG_NORM: begin
        // hold the mantissa in [1,2) and shift the carry into the fraction
        f    <= {f[14:0], t_c[31]};
        m    <= t_c[31] ? (t_c >> 1) : t_c;
        step <= step + 5'd1;
      end
      ST_LOG_EXP: begin
        kreg <= e_c[21:16];
        g    <= e_c[15:0];
        r    <= 31'd1 << 30;
        step <= 5'd1;
      end
      ST_EXP_UPD: begin
        if (g[4'(5'd16 - step)]) begin
          r <= prod[60:30];
        end
        step <= step + 5'd1;
      end
      ST_FIN: begin
        sumc      <= sumc_c;
        lobe_byte <= 8'(((24'(sumc_c) << 8) - 24'(sumc_c) + 24'd8192) >> 14);
      end
      ST_BR_G:   f16 <= 34'((prod64 + 64'sd1073741824 + 64'sd8192) >>> 14);
      ST_BR_H:   g16 <= 50'((prod + 68'sd32768) >>> 16);
      ST_BR_LO:  acc <= prod64 <<< 17;
      ST_BR_D:   acc <= acc + prod64;
      ST_BR_SUM: brdf_value <= sat_c;
      default: ;
    endcase
    // advance to the next lobe once its power term is known
    if (pw_done) begin
      sum <= sum + SUM_W'(pw_val);
      idx <= idx + CNT_W'(1);
    end
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_all_lobes_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (idx == cnt))
    else $error("lobe sum finished with lobes left over");

  a_power_bound: assert property (@(posedge clk) disable iff (rst)
    pw_done |-> (pw_val <= 15'd16384))
    else $error("lobe power term above one");

  a_table_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (op == OP_TABLE || op == OP_NONE)) |-> (brdf_value == 32'sd0))
    else $error("table entry or empty operation with non-zero BRDF");

  a_byte_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && op != OP_NONE) |-> (lobe_byte == byte_c[7:0]))
    else $error("lobe byte does not match the clamped sum");
`endif

endmodule

`default_nettype wire
